[sv/gbw_pkg.sv]
// ----------------------------------------------------------------------------
// gbw_pkg
// Shared types and constants for the grid search through a waypoint.
// ----------------------------------------------------------------------------
`default_nettype none

package gbw_pkg;

  // Cell kinds as they arrive on the input channel.
  localparam logic [2:0] KIND_OPEN     = 3'd0;
  localparam logic [2:0] KIND_WALL     = 3'd1;
  localparam logic [2:0] KIND_START    = 3'd2;
  localparam logic [2:0] KIND_WAYPOINT = 3'd3;
  localparam logic [2:0] KIND_EXIT     = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  // Largest value the result field can show.
  localparam logic [14:0] STEPS_MAX = 15'h7FFF;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_LOAD,
    S_CHK,
    S_CLEAR,
    S_SEED,
    S_POP,
    S_POPW,
    S_NRD,
    S_NEV,
    S_OUT
  } state_t;

  // Write controls for the per-cell wall and visited stores.
  typedef struct packed {
    logic wall_we;
    logic wall_wd;
    logic seen_we;
    logic seen_wd;
  } gm_ctl_t;

endpackage

`default_nettype wire

[sv/gbw_grid_mem.sv]
// ----------------------------------------------------------------------------
// gbw_grid_mem
// Per-cell wall and visited bits, one shared address, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module gbw_grid_mem
  import gbw_pkg::*;
#(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] addr,
  input  wire gm_ctl_t       ctl,
  output logic               wall_rd,
  output logic               seen_rd
);

  logic wall_mem [DEPTH];
  logic seen_mem [DEPTH];

  // Wall store: written while the grid loads.
  always_ff @(posedge clk) begin
    if (ctl.wall_we) begin
      wall_mem[addr] <= ctl.wall_wd;
    end
    wall_rd <= wall_mem[addr];
  end

  // Visited store: cleared before each leg, set as cells are queued.
  always_ff @(posedge clk) begin
    if (ctl.seen_we) begin
      seen_mem[addr] <= ctl.seen_wd;
    end
    seen_rd <= seen_mem[addr];
  end

endmodule

`default_nettype wire

[sv/gbw_queue.sv]
// ----------------------------------------------------------------------------
// gbw_queue
// Frontier queue storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gbw_queue #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 42
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Tail write and head read; the sequencer never reads an entry in the
  // cycle it is written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/grid_bfs_via_waypoint_core.sv]
// Loading: one cell item per cycle unless a register write is pending; the last cell of the
// grid starts the search. Search: a check, then per leg a clearing pass over MAX_ROWS*MAX_COLS
// cells and a seed, then per dequeued cell a pop and a wait, per in-grid neighbor a read and an
// evaluate, per edge neighbor a read. The result is offered from S_OUT after the check when a
// marker is missing, after the second leg dequeues its target, or once a leg's queue runs dry.
// Reset (synchronous) sets rows and cols to 128 and clears markers and load position.
// ----------------------------------------------------------------------------
// grid_bfs_via_waypoint_core
// Breadth-first search from start to waypoint and waypoint to exit on a
// loaded grid; reports the summed step count or not reached.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_bfs_via_waypoint_core
  import gbw_pkg::*;
#(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cell_kind,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]      total_steps,
  output logic             reached,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int PW    = $clog2(CELLS);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int QW    = PW + RIW + CIW + PW;

  // Configuration registers and their clamped values.
  logic [7:0]  rows_reg, cols_reg;
  logic [RW-1:0] nr;
  logic [CW-1:0] nc;

  always_comb begin
    if (rows_reg == 8'd0) begin
      nr = RW'(1);
    end else if (32'(rows_reg) > MAX_ROWS) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(rows_reg);
    end
    if (cols_reg == 8'd0) begin
      nc = CW'(1);
    end else if (32'(cols_reg) > MAX_COLS) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(cols_reg);
    end
  end

  // Sequencer and datapath registers.
  state_t state, state_next;
  logic [PW-1:0]  ld_pos, clr;
  logic [RIW-1:0] ld_r;
  logic [CIW-1:0] ld_c;
  logic           have_s, have_w, have_e;
  logic [PW-1:0]  s_pos, w_pos, e_pos;
  logic [RIW-1:0] s_r, w_r;
  logic [CIW-1:0] s_c, w_c;
  logic           leg;
  logic [PW:0]    head, tail;
  logic [PW-1:0]  cur_pos, cur_dist, a_dist;
  logic [RIW-1:0] cur_r;
  logic [CIW-1:0] cur_c;
  logic [1:0]     k;
  logic [14:0]    res_steps;
  logic           res_ok;

  logic in_acc, out_acc, cfg_acc, last_cell;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cfg_acc = cfg_valid && cfg_ready;
  // Register writes are taken only while loading; a pending write holds off cells.
  assign cfg_ready = (state == S_LOAD);
  assign in_ready  = (state == S_LOAD) && !cfg_valid;
  assign last_cell = (CW'(ld_c) + CW'(1) == nc) && (RW'(ld_r) + RW'(1) == nr);

  // Queue entry fields.
  logic [QW-1:0]  q_rd, q_wd;
  logic [PW-1:0]  q_pos, q_dist;
  logic [RIW-1:0] q_r;
  logic [CIW-1:0] q_c;
  assign {q_pos, q_r, q_c, q_dist} = q_rd;

  // Current leg source and destination.
  logic [PW-1:0]  src_pos, dst_pos;
  logic [RIW-1:0] src_r;
  logic [CIW-1:0] src_c;
  assign src_pos = leg ? w_pos : s_pos;
  assign src_r   = leg ? w_r : s_r;
  assign src_c   = leg ? w_c : s_c;
  assign dst_pos = leg ? e_pos : w_pos;

  // Neighbor k of the current cell.
  logic           nb_ok;
  logic [PW-1:0]  nb_pos;
  logic [RIW-1:0] nb_r;
  logic [CIW-1:0] nb_c;

  always_comb begin
    nb_r = cur_r;
    nb_c = cur_c;
    unique case (k)
      2'd0: begin
        nb_ok  = (cur_r != '0);
        nb_r   = cur_r - RIW'(1);
        nb_pos = cur_pos - PW'(nc);
      end
      2'd1: begin
        nb_ok  = (CW'(cur_c) + CW'(1) < nc);
        nb_c   = cur_c + CIW'(1);
        nb_pos = cur_pos + PW'(1);
      end
      2'd2: begin
        nb_ok  = (cur_c != '0);
        nb_c   = cur_c - CIW'(1);
        nb_pos = cur_pos - PW'(1);
      end
      default: begin
        nb_ok  = (RW'(cur_r) + RW'(1) < nr);
        nb_r   = cur_r + RIW'(1);
        nb_pos = cur_pos + PW'(nc);
      end
    endcase
  end

  // Sum of the two legs with saturation.
  logic [PW:0] leg_sum;
  assign leg_sum = {1'b0, a_dist} + {1'b0, q_dist};

  // Memory interfaces.
  logic [PW-1:0] gm_addr;
  gm_ctl_t       gm_ctl;
  logic          wall_rd, seen_rd;
  logic          q_we, q_re;
  logic [PW-1:0] q_waddr;

  gbw_grid_mem #(.DEPTH(CELLS), .AW(PW)) u_grid (
    .clk(clk), .addr(gm_addr), .ctl(gm_ctl), .wall_rd(wall_rd), .seen_rd(seen_rd)
  );

  gbw_queue #(.DEPTH(CELLS), .AW(PW), .DW(QW)) u_queue (
    .clk(clk), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wd),
    .rd_en(q_re), .rd_addr(head[PW-1:0]), .rd_data(q_rd)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:  if (in_acc && last_cell) state_next = S_CHK;
      S_CHK:   state_next = (have_s && have_w && have_e) ? S_CLEAR : S_OUT;
      S_CLEAR: if (clr == PW'(CELLS - 1)) state_next = S_SEED;
      S_SEED:  state_next = S_POP;
      S_POP:   state_next = (head == tail) ? S_OUT : S_POPW;
      S_POPW: begin
        if (q_pos == dst_pos) begin
          state_next = leg ? S_OUT : S_CLEAR;
        end else begin
          state_next = S_NRD;
        end
      end
      S_NRD: begin
        if (nb_ok) begin
          state_next = S_NEV;
        end else if (k == 2'd3) begin
          state_next = S_POP;
        end else begin
          state_next = S_NRD;
        end
      end
      S_NEV:   state_next = (k == 2'd3) ? S_POP : S_NRD;
      S_OUT:   if (!out_valid || out_ready) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  // Memory controls per state.
  always_comb begin
    gm_addr = nb_pos;
    gm_ctl  = '0;
    q_we    = 1'b0;
    q_re    = 1'b0;
    q_waddr = tail[PW-1:0];
    q_wd    = {nb_pos, nb_r, nb_c, cur_dist + PW'(1)};
    unique case (state)
      S_LOAD: begin
        gm_addr        = ld_pos;
        gm_ctl.wall_we = in_acc;
        gm_ctl.wall_wd = (cell_kind == KIND_WALL);
      end
      S_CLEAR: begin
        gm_addr        = clr;
        gm_ctl.seen_we = 1'b1;
        gm_ctl.seen_wd = 1'b0;
      end
      S_SEED: begin
        gm_addr        = src_pos;
        gm_ctl.seen_we = 1'b1;
        gm_ctl.seen_wd = 1'b1;
        q_we           = 1'b1;
        q_waddr        = '0;
        q_wd           = {src_pos, src_r, src_c, PW'(0)};
      end
      S_POP: q_re = (head != tail);
      S_NEV: begin
        gm_ctl.seen_we = !wall_rd && !seen_rd;
        gm_ctl.seen_wd = 1'b1;
        q_we           = !wall_rd && !seen_rd;
      end
      default: ;
    endcase
  end

  // Register updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      rows_reg  <= 8'd128;
      cols_reg  <= 8'd128;
      ld_pos    <= '0;
      ld_r      <= '0;
      ld_c      <= '0;
      have_s    <= 1'b0;
      have_w    <= 1'b0;
      have_e    <= 1'b0;
      s_pos     <= '0;
      w_pos     <= '0;
      e_pos     <= '0;
      out_valid <= 1'b0;
      leg       <= 1'b0;
      clr       <= '0;
    end else begin
      state <= state_next;
      if (out_acc) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (cfg_acc && (cfg_index == REG_ROWS || cfg_index == REG_COLS)) begin
            if (cfg_index == REG_ROWS) begin
              rows_reg <= cfg_data;
            end else begin
              cols_reg <= cfg_data;
            end
            ld_pos <= '0;
            ld_r   <= '0;
            ld_c   <= '0;
            have_s <= 1'b0;
            have_w <= 1'b0;
            have_e <= 1'b0;
            s_pos  <= '0;
            w_pos  <= '0;
            e_pos  <= '0;
          end else if (in_acc) begin
            // Only the first copy of each marker counts.
            if (cell_kind == KIND_START && !have_s) begin
              have_s <= 1'b1;
              s_pos  <= ld_pos;
              s_r    <= ld_r;
              s_c    <= ld_c;
            end
            if (cell_kind == KIND_WAYPOINT && !have_w) begin
              have_w <= 1'b1;
              w_pos  <= ld_pos;
              w_r    <= ld_r;
              w_c    <= ld_c;
            end
            if (cell_kind == KIND_EXIT && !have_e) begin
              have_e <= 1'b1;
              e_pos  <= ld_pos;
            end
            if (last_cell) begin
              ld_pos <= '0;
              ld_r   <= '0;
              ld_c   <= '0;
            end else if (CW'(ld_c) + CW'(1) == nc) begin
              ld_pos <= ld_pos + PW'(1);
              ld_c   <= '0;
              ld_r   <= ld_r + RIW'(1);
            end else begin
              ld_pos <= ld_pos + PW'(1);
              ld_c   <= ld_c + CIW'(1);
            end
          end
        end
        S_CHK: begin
          leg       <= 1'b0;
          clr       <= '0;
          res_ok    <= 1'b0;
          res_steps <= '0;
        end
        S_CLEAR: clr <= clr + PW'(1);
        S_SEED: begin
          head <= '0;
          tail <= (PW+1)'(1);
        end
        S_POP: begin
          if (head != tail) begin
            head <= head + (PW+1)'(1);
          end else begin
            res_ok    <= 1'b0;
            res_steps <= '0;
          end
        end
        S_POPW: begin
          cur_pos  <= q_pos;
          cur_r    <= q_r;
          cur_c    <= q_c;
          cur_dist <= q_dist;
          k        <= 2'd0;
          if (q_pos == dst_pos) begin
            if (leg) begin
              res_ok <= 1'b1;
              if (32'(leg_sum) > 32'(STEPS_MAX)) begin
                res_steps <= STEPS_MAX;
              end else begin
                res_steps <= 15'(leg_sum);
              end
            end else begin
              a_dist <= q_dist;
              leg    <= 1'b1;
              clr    <= '0;
            end
          end
        end
        S_NRD: if (!nb_ok) k <= k + 2'd1;
        S_NEV: begin
          if (!wall_rd && !seen_rd) begin
            tail <= tail + (PW+1)'(1);
          end
          k <= k + 2'd1;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            total_steps <= res_steps;
            reached     <= res_ok;
            have_s      <= 1'b0;
            have_w      <= 1'b0;
            have_e      <= 1'b0;
            s_pos       <= '0;
            w_pos       <= '0;
            e_pos       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/gbw_checker.sv]
// ----------------------------------------------------------------------------
// gbw_checker
// Port-level checks on the result channel of the grid search core.
// ----------------------------------------------------------------------------
`default_nettype none

module gbw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [14:0] total_steps,
  input wire logic        reached
);

  // A stalled result item holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_steps) && $stable(reached))
    else $error("result changed while stalled");

  // A not-reached result carries a zero step count.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reached |-> total_steps == 15'd0)
    else $error("not-reached result with nonzero steps");

  // A new result only appears after the load side has stopped taking cells.
  a_after_search: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while loading");

endmodule

bind grid_bfs_via_waypoint_core gbw_checker u_gbw_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .total_steps(total_steps), .reached(reached)
);

`default_nettype wire
